[hw/rtl/pidc_pkg.sv]
// shared types, widths, codes and saturation helper for the pid controller
`default_nettype none

package pidc_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int COEF_W     = 16;
	localparam int ACC_W      = 32;
	localparam int OPA_W      = ACC_W + 1;
	localparam int OPB_W      = COEF_W + 1;
	localparam int PROD_W     = OPA_W + OPB_W;
	localparam int WIDE_W     = PROD_W + 1;
	localparam int SUM_W      = ACC_W + 3;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int ONE_Q15    = 32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN   = 2'd0,
		CFG_IRATIO = 2'd1,
		CFG_DRATIO = 2'd2
	} cfg_idx_t;

	// operand source of the shared multiplier, also selects the post-scaling
	typedef enum logic [1:0] {
		SRC_ERR = 2'd0,
		SRC_DPV = 2'd1,
		SRC_P   = 2'd2,
		SRC_T   = 2'd3
	} src_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL_P = 7'b0000010,
		ST_MUL_T = 7'b0000100,
		ST_MUL_I = 7'b0001000,
		ST_MUL_D = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		src_t src;
		logic cap_p;
		logic cap_t;
		logic cap_ip;
		logic cap_d;
		logic finish;
	} ctrl_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return v[ACC_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

[hw/rtl/pidc_alu.sv]
// shared multiplier with registered product and term scaling / saturation
`default_nettype none

module pidc_alu (
	input  wire logic                                   clk,
	input  wire pidc_pkg::ctrl_t                        ctrl,
	input  wire logic signed [pidc_pkg::DATA_WIDTH:0]   err,
	input  wire logic signed [pidc_pkg::DATA_WIDTH:0]   dpv,
	input  wire logic signed [pidc_pkg::ACC_W-1:0]      p,
	input  wire logic signed [pidc_pkg::ACC_W-1:0]      t,
	input  wire logic        [pidc_pkg::COEF_W-1:0]     gain,
	input  wire logic        [pidc_pkg::COEF_W-1:0]     iratio,
	input  wire logic        [pidc_pkg::COEF_W-1:0]     dratio,
	output logic signed      [pidc_pkg::ACC_W-1:0]      result
);

	logic signed [pidc_pkg::OPA_W-1:0]  opa;
	logic signed [pidc_pkg::OPB_W-1:0]  opb;
	logic signed [pidc_pkg::PROD_W-1:0] prod_s1;
	pidc_pkg::src_t                     src_s1;
	logic signed [pidc_pkg::WIDE_W-1:0] wide;
	logic signed [pidc_pkg::WIDE_W-1:0] scaled;

	always_comb begin
		case (ctrl.src)
			pidc_pkg::SRC_ERR: begin
				opa = pidc_pkg::OPA_W'(err);
				opb = signed'({1'b0, gain});
			end
			pidc_pkg::SRC_DPV: begin
				opa = pidc_pkg::OPA_W'(dpv);
				opb = signed'({1'b0, gain});
			end
			pidc_pkg::SRC_P: begin
				opa = pidc_pkg::OPA_W'(p);
				opb = signed'({1'b0, iratio});
			end
			pidc_pkg::SRC_T: begin
				opa = pidc_pkg::OPA_W'(t);
				opb = signed'({1'b0, dratio});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			prod_s1 <= opa * opb;
			src_s1  <= ctrl.src;
		end
	end

	// derivative term is negated before its floor shift
	always_comb begin
		if (src_s1 == pidc_pkg::SRC_T) begin
			wide = -(pidc_pkg::WIDE_W'(prod_s1));
		end else begin
			wide = pidc_pkg::WIDE_W'(prod_s1);
		end
		case (src_s1)
			pidc_pkg::SRC_ERR: scaled = wide >>> 1;
			pidc_pkg::SRC_DPV: scaled = wide >>> 1;
			pidc_pkg::SRC_P:   scaled = wide >>> 16;
			pidc_pkg::SRC_T:   scaled = wide >>> 8;
			default:           scaled = wide;
		endcase
		result = pidc_pkg::sat_acc(scaled);
	end

endmodule

`default_nettype wire

[hw/rtl/pidc_seq.sv]
// sequencer stepping one item through the shared multiplier
`default_nettype none

module pidc_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            out_valid,
	input  wire logic            out_stall,
	output logic                 in_stall,
	output pidc_pkg::ctrl_t      ctrl
);

	pidc_pkg::state_t state_q;
	pidc_pkg::state_t state_d;

	always_comb begin
		ctrl     = '0;
		ctrl.src = pidc_pkg::SRC_ERR;
		state_d  = state_q;
		case (state_q)
			pidc_pkg::ST_IDLE: begin
				ctrl.accept = in_valid;
				if (in_valid) begin
					state_d = pidc_pkg::ST_MUL_P;
				end
			end
			pidc_pkg::ST_MUL_P: begin
				ctrl.issue = 1'b1;
				ctrl.src   = pidc_pkg::SRC_ERR;
				state_d    = pidc_pkg::ST_MUL_T;
			end
			pidc_pkg::ST_MUL_T: begin
				ctrl.issue = 1'b1;
				ctrl.src   = pidc_pkg::SRC_DPV;
				ctrl.cap_p = 1'b1;
				state_d    = pidc_pkg::ST_MUL_I;
			end
			pidc_pkg::ST_MUL_I: begin
				ctrl.issue = 1'b1;
				ctrl.src   = pidc_pkg::SRC_P;
				ctrl.cap_t = 1'b1;
				state_d    = pidc_pkg::ST_MUL_D;
			end
			pidc_pkg::ST_MUL_D: begin
				ctrl.issue  = 1'b1;
				ctrl.src    = pidc_pkg::SRC_T;
				ctrl.cap_ip = 1'b1;
				state_d     = pidc_pkg::ST_SUM;
			end
			pidc_pkg::ST_SUM: begin
				ctrl.cap_d = 1'b1;
				state_d    = pidc_pkg::ST_FIN;
			end
			pidc_pkg::ST_FIN: begin
				// wait for a free output slot
				ctrl.finish = !out_valid || !out_stall;
				if (ctrl.finish) begin
					state_d = pidc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pidc_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != pidc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pid_with_clamped_integrator_top.sv]
// top level of the pid controller with clamped, back-calculated integrator
//
// input channel: measured and setpoint (signed, 8 fraction bits) with
// in_valid / in_stall; an item is taken when in_valid is high and in_stall low.
// output channel: drive (q1.15, 0..32768) and saturated with out_valid /
// out_stall; one result item per input item, held in an output register.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// gain, 1 integral ratio, 2 derivative ratio, other indexes are ignored.
// cfg_ready is always high; write only while no item is in flight.
// sequence: the item is taken in the idle state, then four passes through the
// single shared multiplier (error, measurement step, integral, derivative),
// a sum state for the last product and the integral sum, and a finish state that
// clamps and loads the output register before the return to idle.
// in_stall is high outside idle: a new item is taken only once the last is done.
// when out_stall holds a waiting result, the block still accepts and works
// on the next item, then waits in its finish state until the output slot frees.
// reset: gain 1.0, ratios 0, integrator and previous measurement 0, no
// result pending.
`default_nettype none

module pid_with_clamped_integrator_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [pidc_pkg::DATA_WIDTH-1:0] measured,
	input  wire logic signed [pidc_pkg::DATA_WIDTH-1:0] setpoint,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic             [pidc_pkg::OUT_W-1:0]     drive,
	output logic                                       saturated,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [pidc_pkg::COEF_W-1:0]    cfg_data
);

	localparam logic signed [pidc_pkg::SUM_W-1:0] ONE_S = pidc_pkg::SUM_W'(pidc_pkg::ONE_Q15);

	pidc_pkg::ctrl_t ctrl;

	logic [pidc_pkg::COEF_W-1:0]            gain_q;
	logic [pidc_pkg::COEF_W-1:0]            iratio_q;
	logic [pidc_pkg::COEF_W-1:0]            dratio_q;
	logic [pidc_pkg::OUT_W-1:0]             integ_q;
	logic signed [pidc_pkg::DATA_WIDTH-1:0] prev_q;

	logic signed [pidc_pkg::DATA_WIDTH:0]   err_q;
	logic signed [pidc_pkg::DATA_WIDTH:0]   dpv_q;
	logic signed [pidc_pkg::ACC_W-1:0]      p_q;
	logic signed [pidc_pkg::ACC_W-1:0]      t_q;
	logic signed [pidc_pkg::ACC_W-1:0]      ip_q;
	logic signed [pidc_pkg::ACC_W-1:0]      i_q;
	logic signed [pidc_pkg::ACC_W-1:0]      d_q;
	logic signed [pidc_pkg::ACC_W-1:0]      alu_result;

	logic [pidc_pkg::OUT_W-1:0]             drive_q;
	logic                                   sat_q;
	logic                                   out_valid_q;

	logic signed [pidc_pkg::SUM_W-1:0]      raw;
	logic signed [pidc_pkg::SUM_W-1:0]      next_int;
	logic                                   above;
	logic                                   below;
	logic [pidc_pkg::OUT_W-1:0]             drive_d;
	logic [pidc_pkg::OUT_W-1:0]             integ_d;

	pidc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_valid (out_valid_q),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.ctrl      (ctrl)
	);

	pidc_alu u_alu (
		.clk    (clk),
		.ctrl   (ctrl),
		.err    (err_q),
		.dpv    (dpv_q),
		.p      (p_q),
		.t      (t_q),
		.gain   (gain_q),
		.iratio (iratio_q),
		.dratio (dratio_q),
		.result (alu_result)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= pidc_pkg::COEF_W'(256);
			iratio_q <= '0;
			dratio_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pidc_pkg::cfg_idx_t'(cfg_index))
				pidc_pkg::CFG_GAIN:   gain_q   <= cfg_data;
				pidc_pkg::CFG_IRATIO: iratio_q <= cfg_data;
				pidc_pkg::CFG_DRATIO: dratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture and intermediate terms
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			err_q <= (pidc_pkg::DATA_WIDTH+1)'(setpoint) - (pidc_pkg::DATA_WIDTH+1)'(measured);
			dpv_q <= (pidc_pkg::DATA_WIDTH+1)'(measured) - (pidc_pkg::DATA_WIDTH+1)'(prev_q);
		end
		if (ctrl.cap_p) begin
			p_q <= alu_result;
		end
		if (ctrl.cap_t) begin
			t_q <= alu_result;
		end
		if (ctrl.cap_ip) begin
			ip_q <= alu_result;
		end
		if (ctrl.cap_d) begin
			d_q <= alu_result;
			i_q <= pidc_pkg::sat_acc(pidc_pkg::WIDE_W'(signed'({1'b0, integ_q}))
				+ pidc_pkg::WIDE_W'(ip_q));
		end
	end

	// output clamp and integrator back-calculation
	always_comb begin
		raw   = pidc_pkg::SUM_W'(p_q) + pidc_pkg::SUM_W'(i_q) + pidc_pkg::SUM_W'(d_q);
		above = raw > ONE_S;
		below = raw < 0;
		if (above) begin
			next_int = ONE_S - pidc_pkg::SUM_W'(p_q) - pidc_pkg::SUM_W'(d_q);
			drive_d  = pidc_pkg::OUT_W'(pidc_pkg::ONE_Q15);
		end else if (below) begin
			next_int = -pidc_pkg::SUM_W'(p_q) - pidc_pkg::SUM_W'(d_q);
			drive_d  = '0;
		end else begin
			next_int = pidc_pkg::SUM_W'(i_q);
			drive_d  = raw[pidc_pkg::OUT_W-1:0];
		end
		if (next_int > ONE_S) begin
			integ_d = pidc_pkg::OUT_W'(pidc_pkg::ONE_Q15);
		end else if (next_int < 0) begin
			integ_d = '0;
		end else begin
			integ_d = next_int[pidc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.accept) begin
				prev_q <= measured;
			end
			if (ctrl.finish) begin
				integ_q     <= integ_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			drive_q <= drive_d;
			sat_q   <= above || below;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

[tb/pid_drive_checker.sv]
// checker for the pid controller: watches the channels, predicts each result item and compares
module pid_drive_checker
	import pidc_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  measured,
	input  logic signed [DATA_WIDTH-1:0]  setpoint,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic        [OUT_W-1:0]       drive,
	input  logic                          saturated,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic        [CFG_IDX_W-1:0]   cfg_index,
	input  logic        [COEF_W-1:0]      cfg_data,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic [OUT_W-1:0] drive;
		logic             saturated;
	} drive_item_t;

	localparam longint SAT_HI     = 64'sd2147483647;
	localparam longint SAT_LO     = -SAT_HI - 64'sd1;
	localparam longint FULL_SCALE = ONE_Q15;

	logic        [COEF_W-1:0]     gain_q   = 16'd256;
	logic        [COEF_W-1:0]     iratio_q = '0;
	logic        [COEF_W-1:0]     dratio_q = '0;
	longint                       integ_q  = 0;
	logic signed [DATA_WIDTH-1:0] last_pv  = '0;
	drive_item_t                  drive_expected[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic longint clamp32(input longint v);
		if (v > SAT_HI) begin
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			return SAT_LO;
		end
		return v;
	endfunction

	// one control step, advances the integrator and the stored measurement
	function automatic drive_item_t next_drive(input logic signed [DATA_WIDTH-1:0] pv,
			input logic signed [DATA_WIDTH-1:0] sp);
		longint      err;
		longint      step;
		longint      p;
		longint      i_sum;
		longint      t;
		longint      d;
		longint      raw;
		longint      integ;
		drive_item_t r;
		err   = longint'(sp) - longint'(pv);
		step  = longint'(pv) - longint'(last_pv);
		p     = clamp32((err * longint'(gain_q)) >>> 1);
		i_sum = clamp32(integ_q + clamp32((p * longint'(iratio_q)) >>> 16));
		t     = clamp32((step * longint'(gain_q)) >>> 1);
		d     = clamp32((-(t * longint'(dratio_q))) >>> 8);
		raw   = p + i_sum + d;
		last_pv = pv;
		if (raw > FULL_SCALE) begin
			integ       = FULL_SCALE - p - d;
			r.drive     = OUT_W'(FULL_SCALE);
			r.saturated = 1'b1;
		end else if (raw < 0) begin
			integ       = -p - d;
			r.drive     = '0;
			r.saturated = 1'b1;
		end else begin
			integ       = i_sum;
			r.drive     = OUT_W'(raw);
			r.saturated = 1'b0;
		end
		if (integ > FULL_SCALE) begin
			integ = FULL_SCALE;
		end
		if (integ < 0) begin
			integ = 0;
		end
		integ_q = integ;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_item_t want;
		if (!arst_n) begin
			gain_q   = 16'd256;
			iratio_q = '0;
			dratio_q = '0;
			integ_q  = 0;
			last_pv  = '0;
			drive_expected.delete();
			pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN: begin
						gain_q = cfg_data;
					end
					CFG_IRATIO: begin
						iratio_q = cfg_data;
					end
					CFG_DRATIO: begin
						dratio_q = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					report_mismatch("result item with nothing expected", 0, drive);
				end else begin
					want = drive_expected.pop_front();
					pending--;
					if (drive !== want.drive) begin
						report_mismatch("drive", want.drive, drive);
					end
					if (saturated !== want.saturated) begin
						report_mismatch("saturated", want.saturated, saturated);
					end
				end
			end
			if (in_valid && !in_stall) begin
				drive_expected.push_back(next_drive(measured, setpoint));
				pending++;
			end
		end
	end

endmodule

[tb/tb_pid_with_clamped_integrator_top.sv]
// testbench top for the pid controller: clock, reset, stimulus, flow control and verdict
module tb_pid_with_clamped_integrator_top;
	import pidc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RUN_LIMIT   = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 12;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 105;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic signed [DATA_WIDTH-1:0] measured  = '0;
	logic signed [DATA_WIDTH-1:0] setpoint  = '0;
	logic                         out_stall = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic        [CFG_IDX_W-1:0]  cfg_index = '0;
	logic        [COEF_W-1:0]     cfg_data  = '0;
	logic                         in_stall;
	logic                         out_valid;
	logic        [OUT_W-1:0]      drive;
	logic                         saturated;
	logic                         cfg_ready;

	int                           fail_count;
	int                           pending;
	int                           cycles       = 0;
	bit                           idle_en      = 1'b1;
	bit                           hold_request = 1'b0;
	logic signed [DATA_WIDTH-1:0] target       = '0;
	logic signed [DATA_WIDTH-1:0] track        = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pid_with_clamped_integrator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.measured  (measured),
		.setpoint  (setpoint),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pid_drive_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.measured   (measured),
		.setpoint   (setpoint),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive      (drive),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side flow control
	always begin
		@(negedge clk);
		if (hold_request) begin
			out_stall = 1'b1;
			repeat (LONG_HOLD) @(negedge clk);
			hold_request = 1'b0;
			out_stall = 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			out_stall = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			out_stall = 1'b0;
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic send_item(input logic signed [DATA_WIDTH-1:0] pv,
			input logic signed [DATA_WIDTH-1:0] sp);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		measured = pv;
		setpoint = sp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering items and wait until every result item is back
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [DATA_WIDTH-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef(input int unsigned span);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			1: return COEF_W'($urandom_range(0, span));
			2: return COEF_W'($urandom);
			default: return 16'd256;
		endcase
	endfunction

	task automatic write_random_config();
		write_reg(CFG_GAIN, pick_coef(1024));
		write_reg(CFG_IRATIO, pick_coef(4096));
		write_reg(CFG_DRATIO, pick_coef(512));
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_UNUSED, COEF_W'($urandom));
		end
	endtask

	// mostly a measurement creeping around a fixed target, some noise and corners
	task automatic send_random();
		int kind;
		logic signed [DATA_WIDTH-1:0] pv;
		logic signed [DATA_WIDTH-1:0] sp;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			track = track + DATA_WIDTH'($urandom_range(0, 128)) - 16'sd64;
			if ($urandom_range(0, 15) == 0 || longint'(track) - longint'(target) > 600
					|| longint'(target) - longint'(track) > 600) begin
				track = target + DATA_WIDTH'($urandom_range(0, 512)) - 16'sd256;
			end
			sp = target;
			pv = track;
		end else if (kind == 7) begin
			sp = DATA_WIDTH'($urandom);
			pv = DATA_WIDTH'($urandom);
		end else if (kind == 8) begin
			sp = corner_value();
			pv = corner_value();
		end else begin
			sp = DATA_WIDTH'($urandom);
			pv = sp + DATA_WIDTH'($urandom_range(0, 1023)) - 16'sd512;
		end
		send_item(pv, sp);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: unity gain, no integral or derivative action
		send_item(16'sd0, 16'sd0);
		send_item(16'sd0, 16'sd128);
		send_item(16'sd0, 16'sd256);
		send_item(16'sd0, 16'sd257);
		send_item(16'sd100, 16'sd0);
		drain();

		// all coefficients at full scale
		write_reg(CFG_GAIN, 16'hffff);
		write_reg(CFG_IRATIO, 16'hffff);
		write_reg(CFG_DRATIO, 16'hffff);
		write_reg(CFG_UNUSED, 16'h0000);
		send_item(-16'sd32768, 16'sd32767);
		send_item(16'sd32767, -16'sd32768);
		send_item(-16'sd32768, -16'sd32768);
		send_item(16'sd32767, 16'sd32767);
		send_item(-16'sd1, 16'sd1);
		drain();

		// integral action, windup against both bounds
		write_reg(CFG_GAIN, 16'd256);
		write_reg(CFG_IRATIO, 16'h4000);
		write_reg(CFG_DRATIO, 16'h0000);
		send_item(16'sd0, 16'sd64);
		send_item(16'sd0, 16'sd64);
		send_item(16'sd0, 16'sd255);
		send_item(16'sd0, 16'sd255);
		send_item(16'sd200, 16'sd0);
		send_item(16'sd32767, -16'sd32768);
		send_item(-16'sd32768, 16'sd32767);
		drain();

		// derivative on measurement, then zero gain
		write_reg(CFG_DRATIO, 16'd256);
		send_item(-16'sd256, 16'sd0);
		send_item(-16'sd200, 16'sd0);
		send_item(-16'sd150, 16'sd0);
		drain();
		write_reg(CFG_GAIN, 16'h0000);
		send_item(16'sd100, 16'sd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_random_config();
			target = DATA_WIDTH'($urandom);
			track  = target;
			if (ph == PHASES - 1) begin
				idle_en = 1'b0;
			end
			if (ph == 2) begin
				hold_request = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random();
				if (ph == 4 && n == PHASE_ITEMS / 2) begin
					drain();
				end
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_alu.sv
hw/rtl/pidc_seq.sv
hw/rtl/pid_with_clamped_integrator_top.sv
tb/pid_drive_checker.sv
tb/tb_pid_with_clamped_integrator_top.sv
